@@ rtl/stx_length_frame_receiver_macros.svh @@
// Assertion macros used by the checker file of the frame receiver.
`ifndef STX_LENGTH_FRAME_RECEIVER_MACROS_SVH
`define STX_LENGTH_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define SLFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define SLFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/slfr_pkg.sv @@
// Package: types and constants of the length framed receiver.
package slfr_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 9;
  localparam int HDR_W  = 4;

  localparam logic [BYTE_W-1:0] START_BYTE         = 8'h02;
  localparam logic [BYTE_W-1:0] ONE_BYTE_LENGTH    = 8'h01;
  localparam logic [HDR_W-1:0]  HEADER_MIN         = 4'd2;
  localparam logic [HDR_W-1:0]  HEADER_BYTES_RESET = 4'd4;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  byte_position;
    logic              frame_end;
    logic              checksum_good;
    logic              frame_ready;
  } result_t;

endpackage

@@ rtl/slfr_in_reg.sv @@
// Input register: holds one received item until the frame logic takes it.
module slfr_in_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [slfr_pkg::BYTE_W-1:0] rx_byte,
  input  logic                      take,
  output logic                      q_valid,
  output logic [slfr_pkg::BYTE_W-1:0] q_byte
);
  import slfr_pkg::*;

  logic load;

  assign in_stall = q_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (load) begin
      q_valid <= 1'b1;
    end else if (take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_byte <= rx_byte;
    end
  end

endmodule

@@ rtl/slfr_frame_core.sv @@
// Frame tracker: start hunt, header and body counting, running XOR check.
module slfr_frame_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [slfr_pkg::HDR_W-1:0]  header_bytes,
  input  logic                       step,
  input  logic [slfr_pkg::BYTE_W-1:0] b,
  output logic                       res_valid,
  output slfr_pkg::result_t          res
);
  import slfr_pkg::*;

  phase_t            phase, phase_next;
  logic [POS_W-1:0]  position, position_next;
  logic [BYTE_W-1:0] frame_length, frame_length_next;
  logic [BYTE_W-1:0] running_xor, running_xor_next;
  logic [BYTE_W-1:0] check_byte, check_byte_next;
  logic              ready_flag, ready_flag_next;
  logic [HDR_W-1:0]  hsize;

  assign hsize = (header_bytes < HEADER_MIN) ? HEADER_MIN : header_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      position     <= '0;
      frame_length <= '0;
      running_xor  <= '0;
      check_byte   <= '0;
      ready_flag   <= 1'b0;
    end else begin
      phase        <= phase_next;
      position     <= position_next;
      frame_length <= frame_length_next;
      running_xor  <= running_xor_next;
      check_byte   <= check_byte_next;
      ready_flag   <= ready_flag_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    position_next     = position;
    frame_length_next = frame_length;
    running_xor_next  = running_xor;
    check_byte_next   = check_byte;
    ready_flag_next   = ready_flag;
    res_valid         = 1'b0;
    res               = '0;
    if (step) begin
      unique case (phase)
        PH_HEADER, PH_BODY: begin
          res_valid         = 1'b1;
          res.frame_byte    = b;
          res.byte_position = position;
          if (position == POS_W'(1)) begin
            // length byte: seed XOR and check byte for short lengths
            frame_length_next = b;
            if (b == '0) begin
              running_xor_next = '0;
              check_byte_next  = START_BYTE;
            end else if (b == ONE_BYTE_LENGTH) begin
              running_xor_next = START_BYTE;
              check_byte_next  = ONE_BYTE_LENGTH;
            end else begin
              running_xor_next = START_BYTE ^ b;
              check_byte_next  = '0;
            end
          end else if (position < {1'b0, frame_length}) begin
            running_xor_next = running_xor ^ b;
          end else if (position == {1'b0, frame_length}) begin
            check_byte_next = b;
          end
          position_next = position + POS_W'(1);
          if (phase == PH_HEADER) begin
            if (position_next >= POS_W'(hsize)) begin
              phase_next = PH_BODY;
            end
          end else if (position >= {1'b0, frame_length_next}) begin
            res.frame_end     = 1'b1;
            res.checksum_good = (running_xor_next == check_byte_next);
            ready_flag_next   = (running_xor_next == check_byte_next);
            phase_next        = PH_IDLE;
          end
          res.frame_ready = ready_flag_next;
        end
        default: begin
          phase_next = PH_IDLE;
          if (b == START_BYTE) begin
            res_valid         = 1'b1;
            res.frame_byte    = b;
            res.byte_position = '0;
            res.frame_ready   = ready_flag;
            position_next     = POS_W'(1);
            frame_length_next = '0;
            running_xor_next  = '0;
            check_byte_next   = '0;
            phase_next        = PH_HEADER;
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/slfr_out_reg.sv @@
// Result register: holds one result item until the consumer takes it.
module slfr_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  slfr_pkg::result_t d,
  output logic              space,
  output logic              out_valid,
  input  logic              out_stall,
  output slfr_pkg::result_t q
);
  import slfr_pkg::*;

  assign space = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      q <= d;
    end
  end

endmodule

@@ rtl/stx_length_frame_receiver.sv @@
// Top level of the start/length framed byte receiver with XOR checksum.
// Received bytes enter an input register; a frame tracker then
// drops bytes outside a frame, numbers every captured byte and, on the byte
// at or past the length index, compares the running XOR of bytes 0 to L-1
// with the byte at index L and updates the ready flag. One byte is taken per
// clock cycle when the output side does not stall; a captured byte passes
// from the input register through the frame state update into the result
// register. Dropped bytes produce no result item. header_bytes is written
// through cfg_wr_en and cfg_wr_data; the user must write it only while the
// receiver is idle, which the block itself does not enforce. Values below 2
// act as 2.
module stx_length_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  frame_byte,
  output logic [8:0]  byte_position,
  output logic        frame_end,
  output logic        checksum_good,
  output logic        frame_ready
);
  import slfr_pkg::*;

  logic [HDR_W-1:0]  header_bytes;
  logic              q_valid;
  logic [BYTE_W-1:0] q_byte;
  logic              space;
  logic              advance;
  logic              res_valid;
  result_t           res;
  result_t           out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= HEADER_BYTES_RESET;
    end else if (cfg_wr_en) begin
      header_bytes <= cfg_wr_data;
    end
  end

  assign advance = q_valid && space;

  slfr_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .take     (advance),
    .q_valid  (q_valid),
    .q_byte   (q_byte)
  );

  slfr_frame_core u_core (
    .clk          (clk),
    .rst          (rst),
    .header_bytes (header_bytes),
    .step         (advance),
    .b            (q_byte),
    .res_valid    (res_valid),
    .res          (res)
  );

  slfr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .d         (res),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .q         (out_q)
  );

  assign frame_byte    = out_q.frame_byte;
  assign byte_position = out_q.byte_position;
  assign frame_end     = out_q.frame_end;
  assign checksum_good = out_q.checksum_good;
  assign frame_ready   = out_q.frame_ready;

endmodule

@@ rtl/slfr_checker.sv @@
// Port-level checker for the frame receiver, bound to the top level.
`include "stx_length_frame_receiver_macros.svh"

module slfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] frame_byte,
  input logic [8:0] byte_position,
  input logic       frame_end,
  input logic       checksum_good,
  input logic       frame_ready
);
  import slfr_pkg::*;

  `SLFR_ASSERT_NOW(a_good_only_at_end, out_valid && checksum_good, frame_end,
    "checksum_good without frame_end")

  `SLFR_ASSERT_NOW(a_ready_follows_check, out_valid && frame_end,
    frame_ready == checksum_good, "ready flag differs from checksum result at frame end")

  `SLFR_ASSERT_NOW(a_start_at_zero, out_valid && byte_position == '0,
    frame_byte == START_BYTE && !frame_end, "position 0 is not a start byte")

  `SLFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(frame_byte) && $stable(byte_position) && $stable(frame_ready),
    "stalled result item changed")

  `SLFR_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
    in_valid && $stable(rx_byte), "stalled input item changed")

endmodule

bind stx_length_frame_receiver slfr_checker u_slfr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .rx_byte       (rx_byte),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .frame_byte    (frame_byte),
  .byte_position (byte_position),
  .frame_end     (frame_end),
  .checksum_good (checksum_good),
  .frame_ready   (frame_ready)
);
